@@ rtl/cqsm_pkg.sv @@
// ----------------------------------------------------------------------------
// cqsm_pkg
// Types and codes shared by the search/min-max ring queue and its cells.
// ----------------------------------------------------------------------------
package cqsm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 3;
  localparam int unsigned OccW  = 4;

  // operation codes; code 3 is a no-op
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_SRCH = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [DataW-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
    status_e                 status;
    logic [OccW-1:0]         occupancy;
    logic signed [DataW-1:0] min_value;
    logic signed [DataW-1:0] max_value;
  } rsp_t;

  // running result of the scan wave as it moves along the cell row
  typedef struct packed {
    logic                    any;   // an occupied cell has been seen
    logic                    hit;   // an occupied cell matched the key
    logic signed [DataW-1:0] min;
    logic signed [DataW-1:0] max;
  } wave_t;

endpackage : cqsm_pkg

@@ rtl/cqsm_cell.sv @@
// ----------------------------------------------------------------------------
// cqsm_cell
// One ring slot: holds its entry and folds it into the passing scan wave.
// ----------------------------------------------------------------------------
module cqsm_cell import cqsm_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned INDEX = 0,
  parameter int unsigned SLOT_W = $clog2(DEPTH),
  parameter int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // entry write
  input  logic                    we_i,
  input  logic signed [DataW-1:0] wdata_i,
  output logic signed [DataW-1:0] entry_o,
  // queue state, stable during a scan
  input  logic [SLOT_W-1:0]       head_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic signed [DataW-1:0] key_i,
  // scan wave from the left neighbor
  input  logic                    valid_i,
  input  wave_t                   wave_i,
  input  logic [SLOT_W-1:0]       age_i,
  // scan wave to the right neighbor
  output logic                    valid_o,
  output wave_t                   wave_o,
  output logic [SLOT_W-1:0]       age_o
);

  localparam logic [SLOT_W-1:0] Idx = SLOT_W'(INDEX);

  logic signed [DataW-1:0] entry_q;
  logic                    valid_q;
  wave_t                   wave_q, wave_d;
  logic [SLOT_W-1:0]       age_q, age_d;
  logic [SLOT_W:0]         age_wrap;
  logic [SLOT_W-1:0]       my_age;
  logic                    occupied;

  // distance from the head slot going forward around the ring
  assign age_wrap = {1'b0, Idx} + (SLOT_W+1)'(DEPTH) - {1'b0, head_i};
  assign my_age   = (Idx >= head_i) ? (Idx - head_i) : age_wrap[SLOT_W-1:0];
  assign occupied = CNT_W'(my_age) < count_i;

  always_comb begin
    wave_d = wave_i;
    age_d  = age_i;
    if (occupied) begin
      wave_d.any = 1'b1;
      if (!wave_i.any || entry_q < wave_i.min) wave_d.min = entry_q;
      if (!wave_i.any || entry_q > wave_i.max) wave_d.max = entry_q;
      if (entry_q == key_i && (!wave_i.hit || my_age < age_i)) begin
        wave_d.hit = 1'b1;
        age_d      = my_age;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) entry_q <= wdata_i;
    wave_q <= wave_d;
    age_q  <= age_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign wave_o  = wave_q;
  assign age_o   = age_q;

endmodule : cqsm_cell

@@ rtl/circular_queue_with_search_minmax.sv @@
// ----------------------------------------------------------------------------
// circular_queue_with_search_minmax
// Ring-buffer queue of signed words with enqueue, dequeue and equality
// search; every transaction reports occupancy and the held min and max.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------
//  command   | start, busy             | item_i   (operation, data)
//  result    | result_valid_o (strobe) | result_o (value, position, status,
//            |                         |           occupancy, min, max)
//
//  A command is taken when start is high and busy is low. The queue state
//  is updated at that edge, then a scan wave crosses the row of DEPTH slot
//  cells, one cell per cycle, collecting min, max and the oldest match.
//  The result strobe is registered from the wave leaving the last cell; busy
//  drops with it, so the next command can be taken at the edge that ends
//  the strobe cycle: a new command is not taken until the last one's result
//  has been strobed; the length of the cell row sets the transaction time.
//  Reset clears pointers, count and all control; entries are not cleared,
//  since only occupied slots are ever read. The receiver cannot stall: the
//  result is on result_o for the single strobe cycle.
// ----------------------------------------------------------------------------
module circular_queue_with_search_minmax import cqsm_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t item_i,
  output logic result_valid_o,
  output rsp_t result_o
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FullCnt  = CNT_W'(DEPTH);

  // ring pointers and fill level
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  // transaction control
  logic busy_q, busy_d;
  logic launch_q;
  logic accept;

  // held command context for the scan
  logic [1:0]              op_q;
  logic signed [DataW-1:0] key_q;
  logic signed [DataW-1:0] value_q, value_d;
  status_e                 status_q, status_d;

  rsp_t result_q, result_d;
  logic result_valid_q;

  // cell row
  logic signed [DataW-1:0] entries [DEPTH];
  logic                    cell_we [DEPTH];
  logic                    chain_valid [DEPTH+1];
  wave_t                   chain_wave  [DEPTH+1];
  logic [SLOT_W-1:0]       chain_age   [DEPTH+1];

  logic [SLOT_W:0]   hit_sum;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W+PosW-1:0] pos_ext;
  logic [CNT_W+OccW-1:0]  occ_ext;

  assign accept = start && !busy_q;

  // ---- state update at the command edge --------------------------------
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    value_d  = '0;
    status_d = ST_OK;
    if (item_i.operation == OP_ENQ) begin
      if (count_q == FullCnt) begin
        status_d = ST_FULL;
      end else begin
        tail_d  = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
        count_d = count_q + 1'b1;
      end
    end else if (item_i.operation == OP_DEQ) begin
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else begin
        value_d = entries[head_q];
        head_d  = (head_q == LastSlot) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_we[i] = accept && item_i.operation == OP_ENQ && count_q != FullCnt
                   && tail_q == SLOT_W'(i);
    end
  end

  // ---- scan wave enters cell 0 the cycle after the update ---------------
  assign chain_valid[0] = launch_q;
  assign chain_wave[0]  = '0;
  assign chain_age[0]   = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cqsm_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (cell_we[g]),
      .wdata_i (item_i.data),
      .entry_o (entries[g]),
      .head_i  (head_q),
      .count_i (count_q),
      .key_i   (key_q),
      .valid_i (chain_valid[g]),
      .wave_i  (chain_wave[g]),
      .age_i   (chain_age[g]),
      .valid_o (chain_valid[g+1]),
      .wave_o  (chain_wave[g+1]),
      .age_o   (chain_age[g+1])
    );
  end

  // ---- result assembly when the wave leaves the last cell ---------------
  // the wave carries the match age; turn it back into a ring slot
  assign hit_sum  = {1'b0, head_q} + {1'b0, chain_age[DEPTH]};
  assign hit_slot = (hit_sum >= (SLOT_W+1)'(DEPTH))
                    ? SLOT_W'(hit_sum - (SLOT_W+1)'(DEPTH))
                    : hit_sum[SLOT_W-1:0];
  assign pos_ext  = {{PosW{1'b0}}, hit_slot};
  assign occ_ext  = {{OccW{1'b0}}, count_q};

  always_comb begin
    result_d           = '0;
    result_d.value     = value_q;
    result_d.status    = status_q;
    result_d.occupancy = occ_ext[OccW-1:0];
    if (op_q == OP_SRCH) begin
      if (chain_wave[DEPTH].hit) begin
        result_d.position = pos_ext[PosW-1:0];
        result_d.status   = ST_OK;
      end else begin
        result_d.status   = ST_NOTFOUND;
      end
    end
    if (chain_wave[DEPTH].any) begin
      result_d.min_value = chain_wave[DEPTH].min;
      result_d.max_value = chain_wave[DEPTH].max;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) busy_d = 1'b1;
    else if (chain_valid[DEPTH]) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q         <= '0;
      tail_q         <= '0;
      count_q        <= '0;
      busy_q         <= 1'b0;
      launch_q       <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      busy_q         <= busy_d;
      launch_q       <= accept;
      result_valid_q <= chain_valid[DEPTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= item_i.operation;
      key_q    <= item_i.data;
      value_q  <= value_d;
      status_q <= status_d;
    end
    if (chain_valid[DEPTH]) result_q <= result_d;
  end

  assign busy           = busy_q;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule : circular_queue_with_search_minmax
